### rtl/hbs_pkg.sv
// Shared constants, codes and controller/datapath types of the heat-bath spin engine.
package hbs_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int NODES_DEF      = 16384;
    localparam int MAX_DEGREE_DEF = 16;

    // Fixed field widths of the item and result.
    localparam int NODE_W   = 14;
    localparam int DRAW_W   = 16;
    localparam int PROB_W   = 17;
    localparam int TIDX_W   = 6;
    localparam int FIELD_W  = 6;
    localparam int MAG_W    = 16;

    // Probability table: one entry per local field from -16 to +16.
    localparam int TABLE_SIZE  = 33;
    localparam int FIELD_LIMIT = 16;

    // Item function codes.
    localparam logic [2:0] FN_SET    = 3'd0;
    localparam logic [2:0] FN_EDGE   = 3'd1;
    localparam logic [2:0] FN_UPDATE = 3'd2;
    localparam logic [2:0] FN_LOAD   = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_SELF = 2'd1;
    localparam logic [1:0] STS_DROP = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load;
        logic exec;
        logic scan;
        logic look;
        logic decide;
        logic push;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic clear_last;
        logic is_update;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/hbs_ifs.sv
// Valid/ready channel interfaces for items and results.
interface hbs_in_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                func;
    logic [hbs_pkg::NODE_W-1:0] node;
    logic [hbs_pkg::NODE_W-1:0] source_node;
    logic                      spin_up;
    logic [hbs_pkg::DRAW_W-1:0] random_draw;
    logic [hbs_pkg::TIDX_W-1:0] table_index;
    logic [hbs_pkg::PROB_W-1:0] table_prob;

    modport source (output valid, func, node, source_node, spin_up, random_draw,
                    table_index, table_prob, input ready);
    modport sink (input valid, func, node, source_node, spin_up, random_draw,
                  table_index, table_prob, output ready);
endinterface

interface hbs_out_if;
    logic                              valid;
    logic                              ready;
    logic                              spin_after;
    logic signed [hbs_pkg::FIELD_W-1:0] local_field;
    logic signed [hbs_pkg::MAG_W-1:0]   magnetization_sum;
    logic [1:0]                        status;

    modport source (output valid, spin_after, local_field, magnetization_sum, status,
                    input ready);
    modport sink (input valid, spin_after, local_field, magnetization_sum, status,
                  output ready);
endinterface

### rtl/hbs_ram.sv
// Generic simple dual-port RAM with registered read data.
module hbs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/hbs_ctrl.sv
// Sequencing state machine of the heat-bath spin engine.
module hbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hbs_pkg::t_dp_stat i_stat,
    output hbs_pkg::t_dp_cmd  o_cmd
);
    import hbs_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_LOOK   = 3'd4;
    localparam logic [2:0] ST_DECIDE = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] r_st;
    logic [2:0] n_st;
    t_dp_cmd    w_cmd;

    // Next state and command decode.
    always_comb begin
        n_st  = r_st;
        w_cmd = '0;
        unique case (r_st)
            ST_CLEAR: begin
                w_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) n_st = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_st = ST_FETCH;
                end
            end
            ST_FETCH: begin
                w_cmd.exec = 1'b1;
                n_st = i_stat.is_update ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                w_cmd.scan = 1'b1;
                if (i_stat.scan_done) n_st = ST_LOOK;
            end
            ST_LOOK: begin
                w_cmd.look = 1'b1;
                n_st = ST_DECIDE;
            end
            ST_DECIDE: begin
                w_cmd.decide = 1'b1;
                n_st = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    w_cmd.push = 1'b1;
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_in_ready = (r_st == ST_IDLE);
    assign o_cmd      = w_cmd;

    // A result leaves only when the output register can take it.
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> i_stat.out_free)
        else $error("result pushed into a full output register");
    // An item is taken only after the clearing pass is over.
    a_load_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> $past(r_st) != ST_CLEAR || $past(i_stat.clear_last))
        else $error("item taken during the clearing pass");
    // A scan always follows an update fetch.
    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_FETCH && i_stat.is_update) |=> r_st == ST_SCAN)
        else $error("update did not enter the scan");
endmodule

### rtl/hbs_datapath.sv
// Datapath: spin, degree, in-list and table memories, neighbor scan and result registers.
module hbs_datapath #(
    parameter int NODES      = hbs_pkg::NODES_DEF,
    parameter int MAX_DEGREE = hbs_pkg::MAX_DEGREE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hbs_pkg::t_dp_cmd                  i_cmd,
    output hbs_pkg::t_dp_stat                 o_stat,
    input  logic [2:0]                        i_func,
    input  logic [hbs_pkg::NODE_W-1:0]        i_node,
    input  logic [hbs_pkg::NODE_W-1:0]        i_source_node,
    input  logic                              i_spin_up,
    input  logic [hbs_pkg::DRAW_W-1:0]        i_random_draw,
    input  logic [hbs_pkg::TIDX_W-1:0]        i_table_index,
    input  logic [hbs_pkg::PROB_W-1:0]        i_table_prob,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_spin_after,
    output logic signed [hbs_pkg::FIELD_W-1:0] o_local_field,
    output logic signed [hbs_pkg::MAG_W-1:0]   o_magnetization_sum,
    output logic [1:0]                        o_status
);
    import hbs_pkg::*;

    localparam int NAW = $clog2(NODES);
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int LAW = $clog2(NODES * MAX_DEGREE);
    localparam int AW  = DW + 1;
    localparam int TAW = $clog2(TABLE_SIZE);
    localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(-NODES);

    // Latched item.
    logic [2:0]        r_func;
    logic [NODE_W-1:0] r_node;
    logic [NODE_W-1:0] r_src;
    logic              r_up;
    logic [DRAW_W-1:0] r_draw;
    logic [TIDX_W-1:0] r_tidx;
    logic [PROB_W-1:0] r_tprob;
    logic              r_in_range;
    logic [LAW-1:0]    r_base;

    // Control and scan state.
    logic [NAW-1:0]        r_clr;
    logic [DW-1:0]         r_deg, n_deg;
    logic [DW-1:0]         r_k, n_k;
    logic                  r_v1, n_v1, r_v2, n_v2;
    logic signed [AW-1:0]  r_acc, n_acc;
    logic signed [FIELD_W-1:0] r_hcl;
    logic                  r_spin_old;
    logic [MAG_W-1:0]      r_total, n_total;

    // Pending result and output register.
    logic                      r_res_spin, n_res_spin;
    logic signed [FIELD_W-1:0] r_res_field, n_res_field;
    logic [1:0]                r_res_status, n_res_status;
    logic                      r_o_valid;
    logic                      r_o_spin;
    logic signed [FIELD_W-1:0] r_o_field;
    logic [MAG_W-1:0]          r_o_mag;
    logic [1:0]                r_o_status;

    // Memory ports.
    logic              spin_we, spin_wdata, spin_re, spin_rd;
    logic [NAW-1:0]    spin_waddr, spin_raddr;
    logic              deg_we, deg_re;
    logic [NAW-1:0]    deg_waddr;
    logic [DW-1:0]     deg_wdata, deg_rd;
    logic              list_we, list_re;
    logic [LAW-1:0]    list_waddr, list_raddr;
    logic [NODE_W-1:0] list_rd;
    logic              prob_we, prob_re;
    logic [TAW-1:0]    prob_raddr;
    logic [PROB_W-1:0] prob_rd;

    logic [NAW-1:0]    w_node_a;
    logic              w_new_spin;
    int                w_acc_i;
    int                w_h;

    assign w_node_a   = NAW'(r_node);
    assign w_new_spin = ({1'b0, r_draw} < prob_rd);

    // Read addresses: the item's node on accept, the neighbor list during the scan.
    // The table is addressed straight from the clamped sum in the lookup cycle.
    always_comb begin
        spin_re    = i_cmd.load || (i_cmd.scan && r_v1);
        spin_raddr = i_cmd.load ? NAW'(i_node) : NAW'(list_rd);
        deg_re     = i_cmd.load;
        list_re    = i_cmd.scan && (r_k != r_deg);
        list_raddr = r_base + LAW'(r_k);
        prob_re    = i_cmd.look;
        prob_raddr = TAW'(w_h + FIELD_LIMIT);
    end

    // Clamp of the summed field to the table range.
    always_comb begin
        w_acc_i = int'(r_acc);
        if (w_acc_i > FIELD_LIMIT) begin
            w_h = FIELD_LIMIT;
        end else if (w_acc_i < -FIELD_LIMIT) begin
            w_h = -FIELD_LIMIT;
        end else begin
            w_h = w_acc_i;
        end
    end

    // Writes and next values for the item's action, the scan and the decision.
    always_comb begin
        spin_we      = 1'b0;
        spin_waddr   = w_node_a;
        spin_wdata   = 1'b0;
        deg_we       = 1'b0;
        deg_waddr    = w_node_a;
        deg_wdata    = '0;
        list_we      = 1'b0;
        list_waddr   = r_base + LAW'(deg_rd);
        prob_we      = 1'b0;
        n_total      = r_total;
        n_deg        = r_deg;
        n_k          = r_k;
        n_v1         = r_v1;
        n_v2         = r_v2;
        n_acc        = r_acc;
        n_res_spin   = r_res_spin;
        n_res_field  = r_res_field;
        n_res_status = r_res_status;

        if (i_cmd.clear_step) begin
            spin_we    = 1'b1;
            spin_waddr = r_clr;
            deg_we     = 1'b1;
            deg_waddr  = r_clr;
        end

        if (i_cmd.exec) begin
            n_deg        = deg_rd;
            n_k          = '0;
            n_v1         = 1'b0;
            n_v2         = 1'b0;
            n_acc        = '0;
            n_res_field  = '0;
            n_res_status = STS_OK;
            n_res_spin   = spin_rd;
            priority if (r_func == FN_LOAD) begin
                prob_we    = ({1'b0, r_tidx} < 7'(TABLE_SIZE));
                n_res_spin = r_in_range && spin_rd;
            end else if (!r_in_range) begin
                n_res_spin = 1'b0;
                n_deg      = '0;
            end else if (r_func == FN_SET) begin
                spin_we    = 1'b1;
                spin_wdata = r_up;
                n_res_spin = r_up;
                if (r_up != spin_rd) begin
                    n_total = r_up ? r_total + MAG_W'(2) : r_total - MAG_W'(2);
                end
            end else if (r_func == FN_EDGE) begin
                if (r_src == r_node) begin
                    n_res_status = STS_SELF;
                end else if (32'(r_src) >= 32'(NODES) || 32'(deg_rd) >= 32'(MAX_DEGREE)) begin
                    n_res_status = STS_DROP;
                end else begin
                    list_we   = 1'b1;
                    deg_we    = 1'b1;
                    deg_wdata = deg_rd + DW'(1);
                end
            end else if (r_func == FN_CLEAR) begin
                deg_we = 1'b1;
            end
        end

        // Three-deep scan: list read, spin read, accumulate.
        if (i_cmd.scan) begin
            if (r_k != r_deg) n_k = r_k + DW'(1);
            n_v1 = (r_k != r_deg);
            n_v2 = r_v1;
            if (r_v2) n_acc = spin_rd ? r_acc + AW'(1) : r_acc - AW'(1);
        end

        if (i_cmd.decide) begin
            spin_we     = 1'b1;
            spin_wdata  = w_new_spin;
            n_res_spin  = w_new_spin;
            n_res_field = r_hcl;
            if (w_new_spin != r_spin_old) begin
                n_total = w_new_spin ? r_total + MAG_W'(2) : r_total - MAG_W'(2);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_total   <= MAG_RESET;
            r_o_valid <= 1'b0;
            r_deg     <= '0;
            r_k       <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            if (i_cmd.clear_step) r_clr <= r_clr + NAW'(1);
            r_total <= n_total;
            r_deg   <= n_deg;
            r_k     <= n_k;
            r_v1    <= n_v1;
            r_v2    <= n_v2;
            if (i_cmd.push) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_node     <= i_node;
            r_src      <= i_source_node;
            r_up       <= i_spin_up;
            r_draw     <= i_random_draw;
            r_tidx     <= i_table_index;
            r_tprob    <= i_table_prob;
            r_in_range <= (32'(i_node) < 32'(NODES));
            r_base     <= LAW'(32'(i_node) * MAX_DEGREE);
        end
        if (i_cmd.exec) r_spin_old <= spin_rd;
        if (i_cmd.look) r_hcl <= FIELD_W'(w_h);
        r_acc        <= n_acc;
        r_res_spin   <= n_res_spin;
        r_res_field  <= n_res_field;
        r_res_status <= n_res_status;
        if (i_cmd.push) begin
            r_o_spin   <= r_res_spin;
            r_o_field  <= r_res_field;
            r_o_mag    <= r_total;
            r_o_status <= r_res_status;
        end
    end

    // Memories.
    hbs_ram #(.WIDTH(1), .DEPTH(NODES)) u_spin (
        .i_clk(i_clk), .i_we(spin_we), .i_waddr(spin_waddr), .i_wdata(spin_wdata),
        .i_re(spin_re), .i_raddr(spin_raddr), .o_rdata(spin_rd)
    );
    hbs_ram #(.WIDTH(DW), .DEPTH(NODES)) u_deg (
        .i_clk(i_clk), .i_we(deg_we), .i_waddr(deg_waddr), .i_wdata(deg_wdata),
        .i_re(deg_re), .i_raddr(NAW'(i_node)), .o_rdata(deg_rd)
    );
    hbs_ram #(.WIDTH(NODE_W), .DEPTH(NODES * MAX_DEGREE)) u_list (
        .i_clk(i_clk), .i_we(list_we), .i_waddr(list_waddr), .i_wdata(r_src),
        .i_re(list_re), .i_raddr(list_raddr), .o_rdata(list_rd)
    );
    hbs_ram #(.WIDTH(PROB_W), .DEPTH(TABLE_SIZE)) u_prob (
        .i_clk(i_clk), .i_we(prob_we), .i_waddr(TAW'(r_tidx)), .i_wdata(r_tprob),
        .i_re(prob_re), .i_raddr(prob_raddr), .o_rdata(prob_rd)
    );

    // Status to the controller.
    assign o_stat.clear_last = (r_clr == NAW'(NODES - 1));
    assign o_stat.is_update  = (r_func == FN_UPDATE) && r_in_range;
    assign o_stat.scan_done  = (r_k == r_deg) && !r_v1 && !r_v2;
    assign o_stat.out_free   = !r_o_valid || i_out_ready;

    assign o_out_valid         = r_o_valid;
    assign o_spin_after        = r_o_spin;
    assign o_local_field       = r_o_field;
    assign o_magnetization_sum = r_o_mag;
    assign o_status            = r_o_status;

    // The total moves in steps of two, so it keeps the parity of the node count.
    a_total_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total[0] == MAG_RESET[0])
        else $error("magnetization sum lost its parity");
    // The scan never reads past the node's in-list.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= r_deg)
        else $error("scan index ran past the in-degree");
    // The total moves by at most one spin flip per cycle.
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total == $past(r_total) || r_total == $past(r_total) + MAG_W'(2)
                            || r_total == $past(r_total) - MAG_W'(2)))
        else $error("magnetization sum jumped");
endmodule

### rtl/heat_bath_spin_update.sv
// Top level of the heat-bath Ising spin engine.
//
//  Channel | Dir | Moves                                      | Handshake
//  i_in    | in  | func, node, source_node, spin_up, draw, tbl | valid/ready
//  o_out   | out | spin_after, local_field, magnetization_sum | valid/ready
//
// Set, add-edge, load and clear items pass through the fetch and done states from
// transfer to result, and the next item can be taken in the cycle after the push.
// An update also passes through the scan, lookup and decide states: the neighbor
// scan reads one in-list entry and one spin per cycle through a three-deep pipeline.
// After reset a clearing pass sets all spins and degrees to zero; no item is taken
// during it. A waiting result sits in the output register while the next item
// is already taken; it only stalls the following push.
module heat_bath_spin_update #(
    parameter int NODES      = hbs_pkg::NODES_DEF,
    parameter int MAX_DEGREE = hbs_pkg::MAX_DEGREE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hbs_in_if.sink     i_in,
    hbs_out_if.source  o_out
);
    import hbs_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_ready;

    // Sequencer.
    hbs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(w_ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    // Memories and arithmetic.
    hbs_datapath #(.NODES(NODES), .MAX_DEGREE(MAX_DEGREE)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .i_func(i_in.func), .i_node(i_in.node), .i_source_node(i_in.source_node),
        .i_spin_up(i_in.spin_up), .i_random_draw(i_in.random_draw),
        .i_table_index(i_in.table_index), .i_table_prob(i_in.table_prob),
        .i_out_ready(o_out.ready), .o_out_valid(o_out.valid),
        .o_spin_after(o_out.spin_after), .o_local_field(o_out.local_field),
        .o_magnetization_sum(o_out.magnetization_sum), .o_status(o_out.status)
    );

    assign i_in.ready = w_ready;
endmodule

### bench/tb.sv
// Self-checking bench for the heat-bath spin engine: random items against a scoreboard.
`timescale 1ns / 100ps

module tb;
    import hbs_pkg::*;

    // Item codes beyond the defined set; the block must treat them as reads.
    localparam logic [2:0] FN_SPARE_LO = 3'd5;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;
    localparam int GRAPH_NODES = 16384;
    localparam int GRAPH_DEG   = 16;
    localparam int ITEM_COUNT  = 2000;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 60;
    localparam int LONG_HOLD   = 400;
    localparam int POOL_TOP    = 23;

    typedef struct packed {
        logic [2:0]        func;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] source_node;
        logic              spin_up;
        logic [DRAW_W-1:0] random_draw;
        logic [TIDX_W-1:0] table_index;
        logic [PROB_W-1:0] table_prob;
    } t_spin_op;

    typedef struct packed {
        logic                     spin_after;
        logic signed [FIELD_W-1:0] local_field;
        logic signed [MAG_W-1:0]   magnetization_sum;
        logic [1:0]               status;
    } t_spin_res;

    // Predicts the result of every accepted item and checks results in order.
    class spin_scoreboard;
        bit                      spin_up_q [GRAPH_NODES];
        int unsigned             degree_q  [GRAPH_NODES];
        logic [NODE_W-1:0]       sources_q [GRAPH_NODES][GRAPH_DEG];
        logic [PROB_W-1:0]       prob_q    [TABLE_SIZE];
        logic signed [MAG_W-1:0] mag_q;
        t_spin_res               pending_q [$];
        int                      mismatches;
        int                      results_seen;
        int                      updates_done;
        int                      edges_refused;

        function void reset_state();
            foreach (spin_up_q[n]) begin
                spin_up_q[n] = 1'b0;
                degree_q[n]  = 0;
            end
            mag_q = MAG_W'(-GRAPH_NODES);
        endfunction

        function void set_spin(int unsigned n, bit up);
            if (spin_up_q[n] != up) begin
                mag_q = up ? mag_q + 16'sd2 : mag_q - 16'sd2;
                spin_up_q[n] = up;
            end
        endfunction

        // Note an accepted input item and queue its predicted result.
        function void note(t_spin_op op);
            t_spin_res r;
            int        h;
            int        k;
            r = '0;
            h = 0;
            case (op.func)
                FN_SET:  set_spin(op.node, op.spin_up);
                FN_EDGE: begin
                    if (op.source_node == op.node) begin
                        r.status = STS_SELF;
                        edges_refused++;
                    end else if (degree_q[op.node] >= GRAPH_DEG) begin
                        r.status = STS_DROP;
                        edges_refused++;
                    end else begin
                        sources_q[op.node][degree_q[op.node]] = op.source_node;
                        degree_q[op.node]++;
                    end
                end
                FN_UPDATE: begin
                    for (k = 0; k < degree_q[op.node]; k++)
                        h += spin_up_q[sources_q[op.node][k]] ? 1 : -1;
                    if (h > FIELD_LIMIT) h = FIELD_LIMIT;
                    if (h < -FIELD_LIMIT) h = -FIELD_LIMIT;
                    r.local_field = FIELD_W'(h);
                    set_spin(op.node, {1'b0, op.random_draw} < prob_q[h + FIELD_LIMIT]);
                    updates_done++;
                end
                FN_LOAD: begin
                    if (op.table_index < TABLE_SIZE)
                        prob_q[op.table_index] = op.table_prob;
                end
                FN_CLEAR: degree_q[op.node] = 0;
                default: ;
            endcase
            r.spin_after        = spin_up_q[op.node];
            r.magnetization_sum = mag_q;
            pending_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check(t_spin_res got);
            t_spin_res want;
            results_seen++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending: spin %0d h %0d m %0d st %0d",
                             got.spin_after, got.local_field, got.magnetization_sum,
                             got.status);
                return;
            end
            want = pending_q.pop_front();
            if (got.spin_after !== want.spin_after || got.local_field !== want.local_field ||
                got.magnetization_sum !== want.magnetization_sum ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: got spin %0d h %0d m %0d st %0d, want spin %0d h %0d m %0d st %0d",
                             results_seen, got.spin_after, got.local_field,
                             got.magnetization_sum, got.status, want.spin_after,
                             want.local_field, want.magnetization_sum, want.status);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    hbs_in_if  in_ch ();
    hbs_out_if out_ch ();

    heat_bath_spin_update u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    spin_scoreboard sb;
    bit  hold_request;
    bit  quiet_in;
    bit  quiet_out;
    int  cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle counter and overall timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Check every result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check({out_ch.spin_after, out_ch.local_field, out_ch.magnetization_sum,
                      out_ch.status});
    end

    // Result receiver with random stalls and one long hold-off on request.
    initial begin
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = quiet_out ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    function automatic logic [NODE_W-1:0] pick_node();
        return ($urandom_range(0, 9) == 0) ? NODE_W'($urandom) :
                                             NODE_W'($urandom_range(0, POOL_TOP));
    endfunction

    // Random item, weighted toward a small, densely connected graph.
    function automatic t_spin_op random_op();
        t_spin_op op;
        int       w;
        op             = '0;
        op.node        = pick_node();
        op.source_node = ($urandom_range(0, 7) == 0) ? op.node : pick_node();
        op.spin_up     = 1'($urandom);
        op.random_draw = DRAW_W'($urandom);
        op.table_index = TIDX_W'($urandom_range(0, 32));
        op.table_prob  = PROB_W'($urandom_range(0, 65536));
        w = $urandom_range(0, 99);
        if (w < 20)      op.func = FN_SET;
        else if (w < 45) op.func = FN_EDGE;
        else if (w < 75) op.func = FN_UPDATE;
        else if (w < 82) begin
            op.func = FN_LOAD;
            if ($urandom_range(0, 3) == 0) begin
                op.table_index = TIDX_W'($urandom);
                op.table_prob  = PROB_W'($urandom);
            end
        end else if (w < 92) op.func = FN_CLEAR;
        else op.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
        return op;
    endfunction

    // Offer one item after a random gap and wait for its transfer.
    task automatic send(t_spin_op op);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        {in_ch.func, in_ch.node, in_ch.source_node, in_ch.spin_up, in_ch.random_draw,
         in_ch.table_index, in_ch.table_prob} <= op;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note(op);
    endtask

    function automatic t_spin_op make_op(logic [2:0] f, int n, int s, bit up, int draw,
                                         int idx, int prob);
        t_spin_op op;
        op = '{f, NODE_W'(n), NODE_W'(s), up, DRAW_W'(draw), TIDX_W'(idx), PROB_W'(prob)};
        return op;
    endfunction

    initial begin
        t_spin_op op;
        int       i;
        sb = new();
        sb.reset_state();
        hold_request = 1'b0;
        quiet_in     = 1'b0;
        quiet_out    = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.func        <= FN_SET;
        in_ch.node        <= '0;
        in_ch.source_node <= '0;
        in_ch.spin_up     <= 1'b0;
        in_ch.random_draw <= '0;
        in_ch.table_index <= '0;
        in_ch.table_prob  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole table first, with zero, one and above-one at the ends.
        for (i = 0; i < TABLE_SIZE; i++)
            send(make_op(FN_LOAD, i, 0, 0, 0, i,
                         (i == 0) ? 0 : (i == 32) ? 65536 : (i == 31) ? 131071 :
                         i * 2048));
        // Directed corners: out-of-range table index, extreme nodes, edge cases.
        send(make_op(FN_LOAD, 16383, 0, 0, 0, 63, 5));
        send(make_op(FN_SET, 16383, 0, 1, 0, 0, 0));
        send(make_op(FN_SET, 0, 0, 1, 0, 0, 0));
        send(make_op(FN_EDGE, 1, 1, 0, 0, 0, 0));
        send(make_op(FN_EDGE, 1, 0, 0, 0, 0, 0));
        send(make_op(FN_EDGE, 1, 16383, 0, 0, 0, 0));
        send(make_op(FN_UPDATE, 1, 0, 0, 0, 0, 0));
        send(make_op(FN_UPDATE, 1, 0, 0, 65535, 0, 0));
        send(make_op(FN_SPARE_HI, 1, 0, 1, 0, 0, 0));
        send(make_op(FN_SPARE_LO, 16383, 16383, 1, 65535, 63, 131071));
        send(make_op(FN_CLEAR, 1, 0, 0, 0, 0, 0));
        send(make_op(FN_UPDATE, 1, 0, 0, 0, 0, 0));
        send(make_op(FN_UPDATE, 16383, 0, 0, 65535, 0, 0));
        // Overfill one in-list so the full case is hit directly.
        for (i = 0; i < GRAPH_DEG + 2; i++)
            send(make_op(FN_EDGE, 2, 16383 - i, 0, 0, 0, 0));
        send(make_op(FN_UPDATE, 2, 0, 0, 0, 0, 0));

        // Random part with quiet stretches, one long receiver hold and one drain.
        for (i = 0; i < ITEM_COUNT; i++) begin
            if (i % 150 == 0) begin
                quiet_in  = ($urandom_range(0, 3) == 0);
                quiet_out = ($urandom_range(0, 3) == 0);
            end
            if (i == ITEM_COUNT / 3) hold_request = 1'b1;
            if (i == 2 * ITEM_COUNT / 3) begin
                in_ch.valid <= 1'b0;
                while (sb.pending_q.size() != 0) @(posedge i_clk);
            end
            op = random_op();
            send(op);
        end
        in_ch.valid <= 1'b0;
        quiet_out = 1'b1;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Covered %0d results: %0d updates, %0d refused or dropped edges.",
                 sb.results_seen, sb.updates_done, sb.edges_refused);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
